@@ rtl/mpwm_pkg.sv @@
// ----------------------------------------------------------------------------
// mpwm_pkg
// Shared types, widths and codes of the multi-pin PWM mask generator.
// ----------------------------------------------------------------------------
package mpwm_pkg;

  localparam int MAX_PINS = 8;
  localparam int IDX_W    = (MAX_PINS > 1) ? $clog2(MAX_PINS) : 1;
  localparam int CNT_W    = $clog2(MAX_PINS + 1);

  localparam int PIN_W    = 5;
  localparam int WIDTH_W  = 16;
  localparam int CYC_W    = 16;
  localparam int SLOTS_W  = 13;
  localparam int SLOT_W   = 12;
  localparam int THR_W    = 13;
  localparam int MASK_W   = 32;
  localparam int PROD_W   = WIDTH_W + SLOTS_W;
  localparam int STEP_W   = $clog2(PROD_W + 1);

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_CYCLE_TIME = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_SLOTS      = 1'b1;

  localparam logic [CYC_W-1:0]   CYCLE_TIME_RST = 16'd20000;
  localparam logic [SLOTS_W-1:0] SLOTS_RST      = 13'd2000;
  localparam logic [SLOTS_W-1:0] SLOTS_MAX      = 13'd4096;
  localparam logic [SLOTS_W-1:0] SLOTS_MIN      = 13'd1;

  typedef enum logic {
    KIND_SET  = 1'b0,
    KIND_TICK = 1'b1
  } kind_e;

  typedef enum logic [1:0] {
    TGT_SET    = 2'd0,
    TGT_CLR    = 2'd1,
    TGT_STATUS = 2'd2
  } target_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_UPDATE
  } ctrl_state_e;

  typedef struct packed {
    kind_e              kind;
    logic [PIN_W-1:0]   pin;
    logic [WIDTH_W-1:0] pulse_us;
  } in_item_t;

  typedef struct packed {
    target_e            target;
    logic [SLOT_W-1:0]  slot;
    logic [MASK_W-1:0]  pin_mask;
    logic               table_full;
  } out_item_t;

  typedef struct packed {
    logic [PIN_W-1:0] pin;
    logic [THR_W-1:0] thr;
  } tbl_entry_t;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    tbl_entry_t       wdata;
    logic             re;
    logic [IDX_W-1:0] raddr;
  } ram_req_t;

  typedef struct packed {
    logic              start;
    logic [PROD_W-1:0] dividend;
    logic [CYC_W-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic              busy;
    logic [PROD_W-1:0] quot;
  } div_rsp_t;

endpackage

@@ rtl/mpwm_ram.sv @@
// ----------------------------------------------------------------------------
// mpwm_ram
// Pin table: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module mpwm_ram
  import mpwm_pkg::*;
(
  input  logic       clk_i,
  input  ram_req_t   req_i,
  output tbl_entry_t rdata_o
);

  tbl_entry_t mem [MAX_PINS];
  tbl_entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rdata_q <= mem[req_i.raddr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/mpwm_div.sv @@
// ----------------------------------------------------------------------------
// mpwm_div
// Restoring divider, one quotient bit per cycle, for the pin thresholds.
// ----------------------------------------------------------------------------
module mpwm_div
  import mpwm_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic              busy_q, busy_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic [CYC_W:0]    rem_q, rem_d;
  logic [PROD_W-1:0] quo_q, quo_d;
  logic [CYC_W-1:0]  dvs_q, dvs_d;

  logic [CYC_W:0]    rem_sh;
  logic              ge;

  // for a nonzero divisor the remainder stays below it, so the shifted value fits CYC_W+1 bits
  assign rem_sh = {rem_q[CYC_W-1:0], quo_q[PROD_W-1]};
  assign ge     = rem_sh >= {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    step_d = step_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      step_d = STEP_W'(PROD_W);
      rem_d  = '0;
      quo_d  = req_i.dividend;
      dvs_d  = req_i.divisor;
    end else if (busy_q) begin
      rem_d  = ge ? (rem_sh - {1'b0, dvs_q}) : rem_sh;
      quo_d  = {quo_q[PROD_W-2:0], ge};
      step_d = step_q - STEP_W'(1);
      if (step_q == STEP_W'(1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.quot = quo_q;

endmodule

@@ rtl/mpwm_ctrl.sv @@
// ----------------------------------------------------------------------------
// mpwm_ctrl
// Sequencer: scans the pin table, builds tick masks, updates thresholds.
// ----------------------------------------------------------------------------
module mpwm_ctrl
  import mpwm_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  in_item_t           item_i,
  output logic               res_valid_o,
  output out_item_t          res_o,
  input  logic [SLOTS_W-1:0] eff_slots_i,
  input  logic [CYC_W-1:0]   cycle_time_i,
  output ram_req_t           ram_req_o,
  input  tbl_entry_t         ram_rdata_i,
  output div_req_t           div_req_o,
  input  div_rsp_t           div_rsp_i
);

  ctrl_state_e       state_q, state_d;
  in_item_t          item_q, item_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [SLOT_W-1:0] slot_q, slot_d;
  logic [CNT_W-1:0]  idx_q, idx_d;
  logic              rvld_q, rvld_d;
  logic [IDX_W-1:0]  ridx_q, ridx_d;
  logic              found_q, found_d;
  logic [IDX_W-1:0]  hit_q, hit_d;
  logic [MASK_W-1:0] mask_q, mask_d;
  out_item_t         res_q, res_d;
  logic              res_valid_q, res_valid_d;

  logic [SLOTS_W-1:0] slot_inc;
  logic [THR_W-1:0]   thr;
  logic               accept;

  assign accept   = start && (state_q == ST_IDLE);
  assign slot_inc = {1'b0, slot_q} + SLOTS_W'(1);
  assign thr      = (div_rsp_i.quot > PROD_W'(eff_slots_i)) ? eff_slots_i
                                                            : div_rsp_i.quot[THR_W-1:0];

  // division starts with the item so it overlaps the table scan
  assign div_req_o.start    = accept && (item_i.kind == KIND_SET);
  assign div_req_o.dividend = PROD_W'(item_i.pulse_us) * PROD_W'(eff_slots_i);
  assign div_req_o.divisor  = cycle_time_i;

  always_comb begin
    state_d     = state_q;
    item_d      = item_q;
    cnt_d       = cnt_q;
    slot_d      = slot_q;
    idx_d       = idx_q;
    rvld_d      = rvld_q;
    ridx_d      = ridx_q;
    found_d     = found_q;
    hit_d       = hit_q;
    mask_d      = mask_q;
    res_d       = res_q;
    res_valid_d = 1'b0;
    ram_req_o   = '0;

    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          item_d  = item_i;
          idx_d   = '0;
          rvld_d  = 1'b0;
          found_d = 1'b0;
          mask_d  = '0;
          state_d = ST_SCAN;
        end
      end

      ST_SCAN: begin
        // consume the entry read last cycle
        if (rvld_q) begin
          if (item_q.kind == KIND_SET) begin
            if (ram_rdata_i.pin == item_q.pin) begin
              found_d = 1'b1;
              hit_d   = ridx_q;
            end
          end else if ((slot_q == '0) || ({1'b0, slot_q} > ram_rdata_i.thr)) begin
            mask_d = mask_q | (MASK_W'(1) << ram_rdata_i.pin);
          end
        end
        if (idx_q < cnt_q) begin
          ram_req_o.re    = 1'b1;
          ram_req_o.raddr = idx_q[IDX_W-1:0];
          ridx_d          = idx_q[IDX_W-1:0];
          rvld_d          = 1'b1;
          idx_d           = idx_q + CNT_W'(1);
        end else begin
          rvld_d = 1'b0;
          if (!rvld_q) begin
            if (item_q.kind == KIND_SET) begin
              state_d = ST_UPDATE;
            end else begin
              res_d.target     = (slot_q == '0) ? TGT_SET : TGT_CLR;
              res_d.slot       = slot_q;
              res_d.pin_mask   = mask_q;
              res_d.table_full = 1'b0;
              res_valid_d      = 1'b1;
              slot_d           = (slot_inc >= eff_slots_i) ? '0 : slot_inc[SLOT_W-1:0];
              state_d          = ST_IDLE;
            end
          end
        end
      end

      ST_UPDATE: begin
        if (!div_rsp_i.busy) begin
          res_d.target     = TGT_STATUS;
          res_d.slot       = '0;
          res_d.pin_mask   = '0;
          res_d.table_full = 1'b0;
          ram_req_o.wdata  = '{pin: item_q.pin, thr: thr};
          if (found_q) begin
            ram_req_o.we    = 1'b1;
            ram_req_o.waddr = hit_q;
          end else if (cnt_q < CNT_W'(MAX_PINS)) begin
            ram_req_o.we    = 1'b1;
            ram_req_o.waddr = cnt_q[IDX_W-1:0];
            cnt_d           = cnt_q + CNT_W'(1);
          end else begin
            res_d.table_full = 1'b1;
          end
          res_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      slot_q      <= '0;
      rvld_q      <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      slot_q      <= slot_d;
      rvld_q      <= rvld_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q  <= item_d;
    idx_q   <= idx_d;
    ridx_q  <= ridx_d;
    found_q <= found_d;
    hit_q   <= hit_d;
    mask_q  <= mask_d;
    res_q   <= res_d;
  end

  assign busy        = (state_q != ST_IDLE);
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

@@ rtl/multi_pin_pwm_mask_generator_top.sv @@
// ----------------------------------------------------------------------------
// multi_pin_pwm_mask_generator_top
// Multi-pin PWM mask generator: pin table, threshold divider, sequencer.
// ----------------------------------------------------------------------------
// One word in, one word out, one at a time. A word is taken when start is
// high and busy is low; its result shows on res_o for exactly one cycle with
// res_valid_o high and cannot be held off, so the receiver must sample it
// then. busy drops in the cycle the result is shown. The time a tick word
// takes is set by the one-read-per-cycle scan of the pin table RAM plus a
// final step to consume the last read. The time a set-width word takes is
// set by the 29-step bit-serial divider that runs beside the table scan.
// Write cycle_time_us and slots_per_period only while busy is low.
// ----------------------------------------------------------------------------
module multi_pin_pwm_mask_generator_top
  import mpwm_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                  start,
  output logic                  busy,
  input  in_item_t              item_i,
  output logic                  res_valid_o,
  output out_item_t             res_o
);

  logic [CYC_W-1:0]   cycle_time_q;
  logic [SLOTS_W-1:0] slots_q;
  logic [SLOTS_W-1:0] eff_slots;

  ram_req_t   ram_req;
  tbl_entry_t ram_rdata;
  div_req_t   div_req;
  div_rsp_t   div_rsp;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cycle_time_q <= CYCLE_TIME_RST;
      slots_q      <= SLOTS_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_CYCLE_TIME: cycle_time_q <= cfg_wdata_i[CYC_W-1:0];
        CFG_SLOTS:      slots_q      <= cfg_wdata_i[SLOTS_W-1:0];
        default:        ;
      endcase
    end
  end

  // zero slots acts as one, anything above the max is clamped
  always_comb begin
    priority if (slots_q == '0) begin
      eff_slots = SLOTS_MIN;
    end else if (slots_q > SLOTS_MAX) begin
      eff_slots = SLOTS_MAX;
    end else begin
      eff_slots = slots_q;
    end
  end

  mpwm_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .item_i       (item_i),
    .res_valid_o  (res_valid_o),
    .res_o        (res_o),
    .eff_slots_i  (eff_slots),
    .cycle_time_i (cycle_time_q),
    .ram_req_o    (ram_req),
    .ram_rdata_i  (ram_rdata),
    .div_req_o    (div_req),
    .div_rsp_i    (div_rsp)
  );

  mpwm_ram u_ram (
    .clk_i   (clk_i),
    .req_i   (ram_req),
    .rdata_o (ram_rdata)
  );

  mpwm_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

endmodule

@@ tb/sv/multi_pin_pwm_mask_generator_top_tb.sv @@
// ----------------------------------------------------------------------------
// multi_pin_pwm_mask_generator_top_tb
// Self-checking bench for the multi-pin PWM mask generator.
// A directed table covers reset, table fill and overflow, and width extremes.
// Random phases follow, each under its own period and slot setting.
// A local pin table and slot counter predict every word not given in the directed table.
// Output words are compared field by field, in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module multi_pin_pwm_mask_generator_top_tb;
  import mpwm_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int NUM_PHASES  = 7;
  localparam int PHASE_WORDS = 65;

  typedef struct {
    in_item_t  w;
    bit        typed;
    out_item_t exp;
  } dir_row_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata_i = '0;
  logic                  start = 1'b0;
  logic                  busy;
  in_item_t              item_i = '0;
  logic                  res_valid_o;
  out_item_t             res_o;

  // mirror of the block's registers and pin table
  logic [CYC_W-1:0]   period_us = CYCLE_TIME_RST;
  logic [SLOTS_W-1:0] slot_cfg  = SLOTS_RST;
  logic [PIN_W-1:0]   tbl_pin  [MAX_PINS];
  bit                 tbl_live [MAX_PINS];
  logic [THR_W-1:0]   tbl_thr  [MAX_PINS];
  int unsigned        tbl_used = 0;
  int unsigned        slot_pos = 0;

  out_item_t   expected_masks[$];
  dir_row_t    directed_rows[$];
  int unsigned fail_count  = 0;
  int unsigned cycle_count = 0;

  // per phase: cycle time, slots write data, sender idle percentage
  int unsigned phase_cyc   [NUM_PHASES] = '{20, 1000, 50, 65535, 0, 1, 20000};
  int unsigned phase_slots [NUM_PHASES] = '{16, 4096, 16'hE007, 1, 0, 16'hFFFF, 2000};
  int unsigned phase_idle  [NUM_PHASES] = '{0, 65, 11, 0, 65, 11, 0};

  multi_pin_pwm_mask_generator_top uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .start       (start),
    .busy        (busy),
    .item_i      (item_i),
    .res_valid_o (res_valid_o),
    .res_o       (res_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  function automatic int unsigned slots_eff();
    if (slot_cfg == '0) return 1;
    if (slot_cfg > SLOTS_MAX) return 4096;
    return slot_cfg;
  endfunction

  // threshold = floor(width * slots / period), saturated at slots
  function automatic logic [THR_W-1:0] width_to_thr(logic [WIDTH_W-1:0] wu);
    longint unsigned s;
    longint unsigned q;
    longint unsigned wl;
    s  = slots_eff();
    wl = wu;
    if (period_us == '0) return THR_W'(s);
    q = (wl * s) / longint'(period_us);
    if (q > s) q = s;
    return THR_W'(q);
  endfunction

  task automatic predict_mask_word(input in_item_t w, output out_item_t r);
    int hit;
    r   = '0;
    hit = -1;
    if (w.kind == KIND_SET) begin
      r.target = TGT_STATUS;
      for (int k = 0; k < tbl_used; k++) begin
        if (tbl_live[k] && tbl_pin[k] == w.pin) begin
          hit = k;
          break;
        end
      end
      if (hit < 0 && tbl_used < MAX_PINS) begin
        hit           = tbl_used;
        tbl_pin[hit]  = w.pin;
        tbl_live[hit] = 1'b1;
        tbl_used++;
      end
      if (hit < 0) r.table_full = 1'b1;
      else tbl_thr[hit] = width_to_thr(w.pulse_us);
    end else begin
      r.target = (slot_pos == 0) ? TGT_SET : TGT_CLR;
      r.slot   = SLOT_W'(slot_pos);
      for (int k = 0; k < tbl_used; k++) begin
        if (tbl_live[k] && (slot_pos == 0 || tbl_thr[k] < slot_pos))
          r.pin_mask[tbl_pin[k]] = 1'b1;
      end
      // counter may sit past the period after a slots change; wraps here
      if (slot_pos + 1 >= slots_eff()) slot_pos = 0;
      else slot_pos = (slot_pos + 1) & 12'hFFF;
    end
  endtask

  task automatic note_mismatch(string what, longint unsigned got, longint unsigned exp);
    if (fail_count < 40)
      $display("MISMATCH %s: got %0h expected %0h at %0t", what, got, exp, $time);
    fail_count++;
  endtask

  always @(posedge clk_i) begin
    out_item_t e;
    if (rst_ni && res_valid_o) begin
      if (expected_masks.size() == 0) begin
        note_mismatch("word with none pending", res_o, 0);
      end else begin
        e = expected_masks.pop_front();
        if (res_o.target !== e.target) note_mismatch("target", res_o.target, e.target);
        if (res_o.slot !== e.slot) note_mismatch("slot", res_o.slot, e.slot);
        if (res_o.pin_mask !== e.pin_mask)
          note_mismatch("pin_mask", res_o.pin_mask, e.pin_mask);
        if (res_o.table_full !== e.table_full)
          note_mismatch("table_full", res_o.table_full, e.table_full);
      end
    end
  end

  task automatic issue_word(input in_item_t w, input bit typed, input out_item_t exp);
    out_item_t pred;
    start  <= 1'b1;
    item_i <= w;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    predict_mask_word(w, pred);
    expected_masks.push_back(typed ? exp : pred);
  endtask

  // random idle gap; item lines carry junk while start is low
  task automatic sender_pause(input int unsigned pct);
    in_item_t junk;
    if (pct != 0 && $urandom_range(99) < pct) begin
      junk.kind     = kind_e'($urandom_range(1));
      junk.pin      = PIN_W'($urandom_range(31));
      junk.pulse_us = WIDTH_W'($urandom_range(16'hFFFF));
      start  <= 1'b0;
      item_i <= junk;
      @(posedge clk_i);
      while ($urandom_range(99) < pct) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk_i);
    while (expected_masks.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    if (idx == CFG_CYCLE_TIME) period_us = data;
    else slot_cfg = data[SLOTS_W-1:0];
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic dir_row_t drow(kind_e k, logic [PIN_W-1:0] p, logic [WIDTH_W-1:0] wu,
                                    bit typed, target_e tg, logic [SLOT_W-1:0] s,
                                    logic [MASK_W-1:0] m, logic full);
    dir_row_t r;
    r.w.kind           = k;
    r.w.pin            = p;
    r.w.pulse_us       = wu;
    r.typed            = typed;
    r.exp.target       = tg;
    r.exp.slot         = s;
    r.exp.pin_mask     = m;
    r.exp.table_full   = full;
    return r;
  endfunction

  initial begin
    in_item_t w;
    int unsigned lim;
    int unsigned sel;
    for (int k = 0; k < MAX_PINS; k++) begin
      tbl_pin[k]  = '0;
      tbl_live[k] = 1'b0;
      tbl_thr[k]  = '0;
    end

    // reset settings: 20000 us period, 2000 slots
    directed_rows.push_back(drow(KIND_TICK, 5'd0,  16'd0,     1, TGT_SET,    12'd0, 32'd0, 1'b0));
    directed_rows.push_back(drow(KIND_TICK, 5'd0,  16'd0,     1, TGT_CLR,    12'd1, 32'd0, 1'b0));
    directed_rows.push_back(drow(KIND_SET,  5'd0,  16'd0,     1, TGT_STATUS, 12'd0, 32'd0, 1'b0));
    directed_rows.push_back(drow(KIND_SET,  5'd31, 16'hFFFF,  1, TGT_STATUS, 12'd0, 32'd0, 1'b0));
    directed_rows.push_back(drow(KIND_TICK, 5'd0,  16'd0,     0, TGT_SET,    12'd0, 32'd0, 1'b0));
    directed_rows.push_back(drow(KIND_SET,  5'd10, 16'd10,    1, TGT_STATUS, 12'd0, 32'd0, 1'b0));
    directed_rows.push_back(drow(KIND_SET,  5'd21, 16'd30,    1, TGT_STATUS, 12'd0, 32'd0, 1'b0));
    // pin already present: threshold rewritten only
    directed_rows.push_back(drow(KIND_SET,  5'd0,  16'd20,    1, TGT_STATUS, 12'd0, 32'd0, 1'b0));
    directed_rows.push_back(drow(KIND_TICK, 5'd0,  16'd0,     0, TGT_SET,    12'd0, 32'd0, 1'b0));
    directed_rows.push_back(drow(KIND_SET,  5'd16, 16'd19999, 1, TGT_STATUS, 12'd0, 32'd0, 1'b0));
    directed_rows.push_back(drow(KIND_SET,  5'd5,  16'd40,    1, TGT_STATUS, 12'd0, 32'd0, 1'b0));
    directed_rows.push_back(drow(KIND_SET,  5'd26, 16'd50,    1, TGT_STATUS, 12'd0, 32'd0, 1'b0));
    directed_rows.push_back(drow(KIND_SET,  5'd12, 16'd60,    1, TGT_STATUS, 12'd0, 32'd0, 1'b0));
    // table now full: new pin dropped
    directed_rows.push_back(drow(KIND_SET,  5'd9,  16'd100,   1, TGT_STATUS, 12'd0, 32'd0, 1'b1));
    directed_rows.push_back(drow(KIND_SET,  5'd12, 16'd0,     1, TGT_STATUS, 12'd0, 32'd0, 1'b0));
    directed_rows.push_back(drow(KIND_TICK, 5'd0,  16'd0,     0, TGT_SET,    12'd0, 32'd0, 1'b0));
    directed_rows.push_back(drow(KIND_SET,  5'd9,  16'hFFFF,  1, TGT_STATUS, 12'd0, 32'd0, 1'b1));
    directed_rows.push_back(drow(KIND_TICK, 5'd31, 16'hFFFF,  0, TGT_SET,    12'd0, 32'd0, 1'b0));
    directed_rows.push_back(drow(KIND_SET,  5'd31, 16'd0,     1, TGT_STATUS, 12'd0, 32'd0, 1'b0));
    directed_rows.push_back(drow(KIND_TICK, 5'd0,  16'd0,     0, TGT_SET,    12'd0, 32'd0, 1'b0));

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i])
      issue_word(directed_rows[i].w, directed_rows[i].typed, directed_rows[i].exp);
    drain();

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      write_reg(CFG_CYCLE_TIME, CFG_DATA_W'(phase_cyc[ph]));
      write_reg(CFG_SLOTS, CFG_DATA_W'(phase_slots[ph]));
      lim = period_us + period_us / 4;
      if (lim > 16'hFFFF) lim = 16'hFFFF;
      for (int n = 0; n < PHASE_WORDS; n++) begin
        sender_pause(phase_idle[ph]);
        w.kind = ($urandom_range(99) < 60) ? KIND_TICK : KIND_SET;
        // mostly rewrite pins already held; some new pins hit the full table
        if ($urandom_range(99) < 80 && tbl_used != 0) w.pin = tbl_pin[$urandom_range(tbl_used - 1)];
        else w.pin = PIN_W'($urandom_range(31));
        sel = $urandom_range(7);
        if (sel == 0) w.pulse_us = '0;
        else if (sel == 1) w.pulse_us = 16'hFFFF;
        else if (sel < 4) w.pulse_us = WIDTH_W'($urandom_range(16'hFFFF));
        else w.pulse_us = WIDTH_W'($urandom_range(lim));
        issue_word(w, 1'b0, '0);
      end
      drain();
    end

    repeat (40) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
